### rtl/core/gas_mix_relaxation_step_top_macros.svh
// assertion macros for the gas mix relaxation step block
// used by the checker module, expects clk_i and rst_ni in scope
`ifndef GAS_MIX_RELAXATION_STEP_TOP_MACROS_SVH
`define GAS_MIX_RELAXATION_STEP_TOP_MACROS_SVH

// same-cycle implication
`define GMRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gmrs check failed");

// next-cycle implication
`define GMRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gmrs check failed");

`endif

### rtl/core/gmrs_pkg.sv
// shared types and constants for the gas mix relaxation step block
// no dependencies
package gmrs_pkg;

  localparam int unsigned CntW   = 30;
  localparam int unsigned TotW   = 31;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned DiffW  = 32;
  localparam int unsigned ProdW  = CfgW + DiffW;
  localparam int unsigned DeltaW = ProdW - 16;
  localparam int unsigned AccW   = 48;
  localparam int unsigned XferW  = 49;

  localparam logic CFG_AMBIENT = 1'b0;
  localparam logic CFG_RATE    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TGT   = 5'b00010,
    S_DIF   = 5'b00100,
    S_RATE  = 5'b01000,
    S_APPLY = 5'b10000
  } state_e;

  typedef struct packed {
    logic busy;
    logic mul_en;
    logic sel_rate;
    logic diff_en;
    logic apply;
  } ctrl_t;

endpackage

### rtl/core/gmrs_mul.sv
// shared registered multiplier, 17 x 32 bits
// depends on gmrs_pkg
module gmrs_mul (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [gmrs_pkg::CfgW-1:0]       a_i,
  input  logic [gmrs_pkg::DiffW-1:0]      b_i,
  output logic [gmrs_pkg::ProdW-1:0]      p_o
);

  logic [gmrs_pkg::ProdW-1:0] p_q;
  logic [gmrs_pkg::ProdW-1:0] p_d;

  assign p_d = {{gmrs_pkg::DiffW{1'b0}}, a_i} * {{gmrs_pkg::CfgW{1'b0}}, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/gmrs_ctrl.sv
// sequencer that steps one tile through the shared multiplier
// depends on gmrs_pkg
module gmrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            exch_i,
  input  logic            out_free_i,
  output gmrs_pkg::ctrl_t ctrl_o
);

  gmrs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.busy     = (state_q != gmrs_pkg::S_IDLE);
    unique case (state_q)
      gmrs_pkg::S_IDLE: begin
        if (accept_i) begin
          state_d = exch_i ? gmrs_pkg::S_TGT : gmrs_pkg::S_APPLY;
        end
      end
      gmrs_pkg::S_TGT: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = gmrs_pkg::S_DIF;
      end
      gmrs_pkg::S_DIF: begin
        ctrl_o.diff_en = 1'b1;
        state_d        = gmrs_pkg::S_RATE;
      end
      gmrs_pkg::S_RATE: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.sel_rate = 1'b1;
        state_d         = gmrs_pkg::S_APPLY;
      end
      gmrs_pkg::S_APPLY: begin
        if (out_free_i) begin
          ctrl_o.apply = 1'b1;
          state_d      = gmrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gmrs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmrs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/gas_mix_relaxation_step_top.sv
// Relaxes the oxygen of each open-sky tile toward an ambient share of the tile's
// total gas and keeps a running transfer sum that clears after the last tile.
// One input word is taken at a time. An exchanging tile (sky tile, nonzero rate)
// passes the target, difference, rate and apply states, and the next word is
// taken only once its result is loaded. The steps are set by the one shared
// 17 x 32 multiplier, which forms first the target and then the scaled difference,
// with the difference step in between. Any other tile goes straight from idle to
// apply. The result sits in an output register, so the finished word waits there
// while the next tile is accepted; a tile whose result finds that register still
// stalled waits in its last step.
// depends on gmrs_pkg, gmrs_ctrl, gmrs_mul
module gas_mix_relaxation_step_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [gmrs_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [gmrs_pkg::CntW-1:0]            o2_count_i,
  input  logic [gmrs_pkg::CntW-1:0]            inert_count_i,
  input  logic                                 is_sky_i,
  input  logic                                 last_tile_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gmrs_pkg::TotW-1:0]            o2_out_o,
  output logic [gmrs_pkg::TotW-1:0]            inert_out_o,
  output logic signed [gmrs_pkg::XferW-1:0]    transfer_total_o,
  output logic                                 last_out_o
);

  localparam int unsigned CntW   = gmrs_pkg::CntW;
  localparam int unsigned TotW   = gmrs_pkg::TotW;
  localparam int unsigned CfgW   = gmrs_pkg::CfgW;
  localparam int unsigned DiffW  = gmrs_pkg::DiffW;
  localparam int unsigned ProdW  = gmrs_pkg::ProdW;
  localparam int unsigned DeltaW = gmrs_pkg::DeltaW;
  localparam int unsigned AccW   = gmrs_pkg::AccW;

  gmrs_pkg::ctrl_t ctrl;

  logic [CfgW-1:0]  amb_q, rate_q;
  logic [CntW-1:0]  o2_q, inert_q;
  logic [TotW-1:0]  total_q;
  logic             last_q, exch_q;
  logic [DiffW-1:0] diff_q, diff_d;
  logic             up_q, up_d;
  logic [AccW-1:0]  acc_q, acc_d;

  logic             out_valid_q, out_valid_d;
  logic [TotW-1:0]  o2_out_q, inert_out_q;
  logic [AccW:0]    xfer_q;
  logic             last_out_q;

  logic             accept;
  logic             exch;
  logic             out_free;
  logic [CfgW-1:0]  mul_a;
  logic [DiffW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;
  logic [DiffW-1:0] target;
  logic [ProdW-1:0] rnd;
  logic [DeltaW-1:0] delta;
  logic [DeltaW:0]  up_sum;
  logic [TotW-1:0]  o2_new, inert_new;
  logic [AccW-1:0]  chg, acc_new;

  assign accept   = in_valid_i && !in_stall_o;
  assign exch     = is_sky_i && (rate_q != '0);
  assign out_free = !out_valid_q || !out_stall_i;

  gmrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .exch_i     (exch),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign mul_a = ctrl.sel_rate ? rate_q : amb_q;
  assign mul_b = ctrl.sel_rate ? diff_q : {1'b0, total_q};

  gmrs_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_stall_o = ctrl.busy;

  // target minus oxygen as sign and magnitude
  assign target = mul_p[DiffW+15:16];
  assign up_d   = (target >= {{(DiffW-CntW){1'b0}}, o2_q});
  assign diff_d = up_d ? (target - {{(DiffW-CntW){1'b0}}, o2_q})
                       : ({{(DiffW-CntW){1'b0}}, o2_q} - target);

  // round half away from zero on the magnitude
  assign rnd    = mul_p + ProdW'(32768);
  assign delta  = rnd[ProdW-1:16];
  assign up_sum = {{(DeltaW+1-CntW){1'b0}}, o2_q} + {1'b0, delta};

  always_comb begin
    o2_new    = {1'b0, o2_q};
    inert_new = {1'b0, inert_q};
    if (exch_q) begin
      if (up_q) begin
        o2_new = (up_sum > {{(DeltaW+1-TotW){1'b0}}, total_q}) ? total_q : up_sum[TotW-1:0];
      end else begin
        o2_new = (delta >= {{(DeltaW-CntW){1'b0}}, o2_q}) ? '0
                 : ({1'b0, o2_q} - {1'b0, delta[CntW-1:0]});
      end
      inert_new = total_q - o2_new;
    end
  end

  assign chg     = {{(AccW-TotW){1'b0}}, o2_new} - {{(AccW-CntW){1'b0}}, o2_q};
  assign acc_new = exch_q ? (acc_q + chg) : acc_q;
  assign acc_d   = last_q ? '0 : acc_new;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.apply) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q       <= '0;
      rate_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gmrs_pkg::CFG_AMBIENT: amb_q  <= cfg_data_i;
          gmrs_pkg::CFG_RATE:    rate_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (ctrl.apply) begin
        acc_q <= acc_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      o2_q    <= o2_count_i;
      inert_q <= inert_count_i;
      total_q <= {1'b0, o2_count_i} + {1'b0, inert_count_i};
      last_q  <= last_tile_i;
      exch_q  <= exch;
    end
    if (ctrl.diff_en) begin
      diff_q <= diff_d;
      up_q   <= up_d;
    end
    if (ctrl.apply) begin
      o2_out_q    <= o2_new;
      inert_out_q <= inert_new;
      xfer_q      <= {acc_new[AccW-1], acc_new};
      last_out_q  <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign o2_out_o         = o2_out_q;
  assign inert_out_o      = inert_out_q;
  assign transfer_total_o = xfer_q;
  assign last_out_o       = last_out_q;

endmodule

### rtl/core/gmrs_checker.sv
// port-level checks for the gas mix relaxation step block, bound to the top level
// depends on gmrs_pkg and gas_mix_relaxation_step_top_macros.svh
`include "gas_mix_relaxation_step_top_macros.svh"

module gmrs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [gmrs_pkg::TotW-1:0]            o2_out_o,
  input logic [gmrs_pkg::TotW-1:0]            inert_out_o,
  input logic signed [gmrs_pkg::XferW-1:0]    transfer_total_o
);

  // a stalled result word stays put
  `GMRS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(o2_out_o) && $stable(inert_out_o) && $stable(transfer_total_o))
  // an accepted word keeps the block busy for the next cycle
  `GMRS_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a new result only appears out of a busy cycle
  `GMRS_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))
  // transfer total is a sign-extended 48-bit value
  `GMRS_ASSERT_NOW(a_xfer_sext, out_valid_o, transfer_total_o[48] == transfer_total_o[47])

endmodule

bind gas_mix_relaxation_step_top gmrs_checker u_gmrs_checker (.*);
